>>> src/chrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV header row splitter package
// Shared constants, payload structures and status codes for the header row
// splitter and its stream interfaces.
// ----------------------------------------------------------------------------
package chrs_pkg;

    // Default sizes of the field text buffer, the column counter and the row.
    localparam int CHRS_HEADER_BYTES = 128;
    localparam int CHRS_MAX_COLUMNS  = 256;
    localparam int CHRS_ROW_BYTES    = 65536;

    // Byte that terminates the header row.
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // Reset values of the configuration registers.
    localparam logic [7:0] SEPARATOR_RESET = 8'd44;
    localparam logic [7:0] WRAPPER_RESET   = 8'd0;
    localparam logic [8:0] COLUMNS_RESET   = 9'd1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SEPARATOR_CHAR   = 2'd0,
        CFG_WRAPPER_CHAR     = 2'd1,
        CFG_EXPECTED_COLUMNS = 2'd2
    } cfg_index_t;

    // Final status codes of a row.
    typedef enum logic [2:0] {
        STATUS_OK              = 3'd0,
        STATUS_EMPTY_LINE      = 3'd1,
        STATUS_COLUMN_MISMATCH = 3'd2,
        STATUS_WRAPPER_MISSING = 3'd3,
        STATUS_NO_NEWLINE      = 3'd4
    } status_t;

    // One input word: a byte of the header row.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       input_ends;
    } in_item_t;

    // One result word.
    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_char;
        logic [7:0]  column_index;
        logic [6:0]  char_offset;
        logic        field_end;
        logic        row_done;
        status_t     status;
        logic [15:0] fault_position;
    } out_item_t;

    // One configuration write.
    typedef struct packed {
        logic [1:0] reg_index;
        logic [8:0] reg_value;
    } cfg_write_t;

endpackage

>>> src/chrs_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one word of type T per handshake between a source and a sink.
// ----------------------------------------------------------------------------
interface chrs_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> src/csv_header_row_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV header row splitter
// Splits a header row into fields, strips wrapper bytes and checks the row.
// A result is written into the output register in the cycle after its byte
// is accepted.
// Throughput: one byte per clock while the output register is empty or draining;
// the row state is updated once per accepted byte and the output register frees as soon as its word is taken.
// Reset: rst_n clears the row state and the output register at once and
// returns the configuration registers to separator 44, no wrapper, 1 column.
// ----------------------------------------------------------------------------
module csv_header_row_splitter
    import chrs_pkg::*;
#(
    parameter int HEADER_BYTES = CHRS_HEADER_BYTES,
    parameter int MAX_COLUMNS  = CHRS_MAX_COLUMNS,
    parameter int ROW_BYTES    = CHRS_ROW_BYTES
) (
    input logic            clk,
    input logic            rst_n,
    chrs_stream_if.sink    in_stream,
    chrs_stream_if.source  out_stream,
    chrs_stream_if.sink    cfg
);

    // Derived widths and limits.
    localparam int PW        = $clog2(ROW_BYTES);
    localparam int LW        = $clog2(HEADER_BYTES);
    localparam int COL_CAP_I = (MAX_COLUMNS - 1) < 255 ? (MAX_COLUMNS - 1) : 255;
    localparam logic [7:0]    COL_CAP   = 8'(COL_CAP_I);
    localparam logic [LW-1:0] TEXT_MAX  = LW'(HEADER_BYTES - 1);
    localparam logic [PW:0]   ROW_LIMIT = (PW + 1)'(ROW_BYTES);

    // Configuration registers.
    logic [7:0] separator_reg;
    logic [7:0] wrapper_reg;
    logic [8:0] columns_reg;

    // Row state.
    logic [PW-1:0] row_position_reg,  row_position_next;
    logic [15:0]   separator_total_reg, separator_total_next;
    logic [PW-1:0] field_start_reg,   field_start_next;
    logic [7:0]    current_column_reg, current_column_next;
    logic [LW-1:0] field_length_reg,  field_length_next;
    logic [7:0]    held_char_reg,     held_char_next;
    logic          held_valid_reg,    held_valid_next;
    logic          fault_seen_reg,    fault_seen_next;
    logic [15:0]   fault_pos_reg,     fault_pos_next;

    // Output register.
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t result;

    logic in_fire;
    logic [7:0] in_byte;
    logic in_ends;

    assign in_byte = in_stream.data.in_byte;
    assign in_ends = in_stream.data.input_ends;

    // A new byte is taken whenever the output register is empty or draining.
    assign in_stream.ready  = !out_valid_reg || out_stream.ready;
    assign in_fire          = in_stream.valid && in_stream.ready;
    assign out_stream.valid = out_valid_reg;
    assign out_stream.data  = out_data_reg;
    assign cfg.ready        = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= SEPARATOR_RESET;
            wrapper_reg   <= WRAPPER_RESET;
            columns_reg   <= COLUMNS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.reg_index)
                CFG_SEPARATOR_CHAR:   separator_reg <= cfg.data.reg_value[7:0];
                CFG_WRAPPER_CHAR:     wrapper_reg   <= cfg.data.reg_value[7:0];
                CFG_EXPECTED_COLUMNS: columns_reg   <= cfg.data.reg_value;
                default:              ;
            endcase
        end
    end

    // Per-byte field splitting, wrapper checking and row status.
    always_comb
    begin
        logic          wrap_on;
        logic          at_start;
        logic          fault_req;
        logic [15:0]   fault_where;
        logic          seen_now;
        logic [15:0]   pos_now;
        logic [PW:0]   pos_inc;
        logic          do_emit;
        logic [7:0]    emit_char;
        logic          clear_row;
        status_t       st;

        wrap_on     = (wrapper_reg != 8'd0);
        at_start    = (row_position_reg == field_start_reg);
        fault_req   = 1'b0;
        fault_where = 16'd0;
        do_emit     = 1'b0;
        emit_char   = 8'd0;
        clear_row   = 1'b0;
        st          = STATUS_OK;
        pos_inc     = {1'b0, row_position_reg} + (PW + 1)'(1);

        row_position_next    = row_position_reg;
        separator_total_next = separator_total_reg;
        field_start_next     = field_start_reg;
        current_column_next  = current_column_reg;
        field_length_next    = field_length_reg;
        held_char_next       = held_char_reg;
        held_valid_next      = held_valid_reg;

        result                = '0;
        result.column_index   = current_column_reg;
        result.status         = STATUS_OK;

        if (in_byte == NEWLINE_BYTE || in_byte == separator_reg)
        begin
            // Field end: check the closing wrapper of the field just ended.
            if (wrap_on)
            begin
                if (at_start)
                begin
                    fault_req   = 1'b1;
                    fault_where = 16'(field_start_reg) + 16'd1;
                end
                else if (held_valid_reg && held_char_reg != wrapper_reg)
                begin
                    fault_req   = 1'b1;
                    fault_where = 16'(row_position_reg) - 16'd1;
                end
            end
        end
        else if (wrap_on)
        begin
            // Opening wrapper check, or hold the byte back one step.
            if (at_start)
            begin
                if (in_byte != wrapper_reg)
                begin
                    fault_req   = 1'b1;
                    fault_where = 16'(row_position_reg) + 16'd1;
                end
            end
            else
            begin
                do_emit         = held_valid_reg;
                emit_char       = held_char_reg;
                held_char_next  = in_byte;
                held_valid_next = 1'b1;
            end
        end
        else
        begin
            do_emit   = 1'b1;
            emit_char = in_byte;
        end

        // Only the first wrapper fault of a row is kept.
        seen_now        = fault_seen_reg || fault_req;
        pos_now         = fault_seen_reg ? fault_pos_reg : fault_where;
        fault_seen_next = seen_now;
        fault_pos_next  = pos_now;

        // Text bytes beyond the buffer length are suppressed.
        if (do_emit && field_length_reg < TEXT_MAX)
        begin
            result.byte_valid  = 1'b1;
            result.out_char    = emit_char;
            result.char_offset = 7'(field_length_reg);
            field_length_next  = field_length_reg + LW'(1);
        end

        if (in_byte == NEWLINE_BYTE)
        begin
            // Final status of the row, checked in priority order.
            if (row_position_reg == '0)
                st = STATUS_EMPTY_LINE;
            else if ({1'b0, separator_total_reg} + 17'd1 != 17'(columns_reg))
                st = STATUS_COLUMN_MISMATCH;
            else if (seen_now)
                st = STATUS_WRAPPER_MISSING;
            else
                st = STATUS_OK;
            result.field_end      = (row_position_reg != '0);
            result.row_done       = 1'b1;
            result.status         = st;
            result.fault_position = (st == STATUS_WRAPPER_MISSING) ? pos_now : 16'd0;
            clear_row             = 1'b1;
        end
        else
        begin
            if (in_byte == separator_reg)
            begin
                // Separator: open the next field.
                result.field_end = 1'b1;
                if (separator_total_reg != 16'hFFFF)
                    separator_total_next = separator_total_reg + 16'd1;
                if (current_column_reg < COL_CAP)
                    current_column_next = current_column_reg + 8'd1;
                field_start_next  = PW'(pos_inc);
                field_length_next = '0;
                held_valid_next   = 1'b0;
                held_char_next    = 8'd0;
            end
            row_position_next = PW'(pos_inc);
            // Row ended or overran without a newline.
            if (in_ends || pos_inc >= ROW_LIMIT)
            begin
                result.row_done       = 1'b1;
                result.status         = STATUS_NO_NEWLINE;
                result.fault_position = 16'd0;
                clear_row             = 1'b1;
            end
        end

        if (clear_row)
        begin
            row_position_next    = '0;
            separator_total_next = 16'd0;
            field_start_next     = '0;
            current_column_next  = 8'd0;
            field_length_next    = '0;
            held_char_next       = 8'd0;
            held_valid_next      = 1'b0;
            fault_seen_next      = 1'b0;
            fault_pos_next       = 16'd0;
        end
    end

    // Row state registers, advanced once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_position_reg    <= '0;
            separator_total_reg <= 16'd0;
            field_start_reg     <= '0;
            current_column_reg  <= 8'd0;
            field_length_reg    <= '0;
            held_char_reg       <= 8'd0;
            held_valid_reg      <= 1'b0;
            fault_seen_reg      <= 1'b0;
            fault_pos_reg       <= 16'd0;
        end
        else if (in_fire)
        begin
            row_position_reg    <= row_position_next;
            separator_total_reg <= separator_total_next;
            field_start_reg     <= field_start_next;
            current_column_reg  <= current_column_next;
            field_length_reg    <= field_length_next;
            held_char_reg       <= held_char_next;
            held_valid_reg      <= held_valid_next;
            fault_seen_reg      <= fault_seen_next;
            fault_pos_reg       <= fault_pos_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_stream.ready)
            out_valid_reg <= in_stream.valid;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= result;
    end

    // Every accepted byte yields a result word in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted byte did not produce a result word");

    // A newline always returns the row to its start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_byte == NEWLINE_BYTE) |=>
            (row_position_reg == '0 && separator_total_reg == 16'd0 && !fault_seen_reg))
        else $error("row state not cleared after newline");

    // A non-zero status is only reported together with the end of a row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status != STATUS_OK) |-> out_data_reg.row_done)
        else $error("status reported without row end");

    // The field text counter never runs past the buffer length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && field_length_reg == TEXT_MAX) |=> !out_data_reg.byte_valid)
        else $error("text byte emitted beyond the buffer length");

endmodule

>>> tb/csv_header_row_splitter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV header row splitter testbench
// Streams header rows into the splitter and checks every result word against
// a cycle-free prediction of the field split. Directed rows cover the empty
// line, column mismatch, missing wrappers and an unterminated row. Random rows
// then follow under a series of register settings, extremes included, with
// random idling on both sides, one long receiver hold-off and one long row
// that is cut off by the end of input.
// ----------------------------------------------------------------------------
module csv_header_row_splitter_test;
    import chrs_pkg::*;

    localparam int unsigned TEXT_LIMIT     = CHRS_HEADER_BYTES - 1;
    localparam int unsigned COLUMN_CAP     = (CHRS_MAX_COLUMNS - 1 < 255) ?
                                             CHRS_MAX_COLUMNS - 1 : 255;
    localparam int unsigned ROW_LIMIT      = CHRS_ROW_BYTES;
    localparam int unsigned PHASE_BYTES    = 40;
    localparam int unsigned HOLD_BYTES     = 60;
    localparam int unsigned LONG_ROW_BYTES = 160;
    localparam int unsigned LONG_HOLD      = 150;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned REPORT_LIMIT   = 50;

    // Ways in which a generated row departs from a well-formed one.
    typedef enum int unsigned {
        ROW_CLEAN,
        ROW_NO_OPENING,
        ROW_NO_CLOSING,
        ROW_CUT_SHORT
    } row_flaw_t;

    logic clk = 1'b0;
    logic rst_n;

    chrs_stream_if #(.T(in_item_t))   in_if ();
    chrs_stream_if #(.T(out_item_t))  out_if ();
    chrs_stream_if #(.T(cfg_write_t)) cfg_if ();

    csv_header_row_splitter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if),
        .cfg        (cfg_if)
    );

    always #1 clk = ~clk;

    // Register copies and row state of the prediction.
    logic [7:0]  sep_reg;
    logic [7:0]  wrap_reg;
    logic [8:0]  cols_reg;
    int unsigned row_pos;
    int unsigned sep_count;
    int unsigned field_start;
    int unsigned field_len;
    int unsigned fault_pos;
    logic [7:0]  column_no;
    logic [7:0]  held_byte;
    bit          held_ok;
    bit          fault_seen;

    // Words waiting to be sent and result words still due.
    in_item_t    header_bytes_q[$];
    out_item_t   split_words_due[$];
    int unsigned bytes_queued;
    int unsigned bytes_taken;
    int unsigned words_checked;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;

    // Idling controls shared between the sequence and the two sides.
    bit          sender_idles;
    bit          receiver_idles;
    int unsigned send_gap;
    int unsigned take_gap;
    int unsigned receiver_hold;

    function automatic void clear_row_state();
        row_pos     = 0;
        sep_count   = 0;
        field_start = 0;
        field_len   = 0;
        fault_pos   = 0;
        column_no   = 8'd0;
        held_byte   = 8'd0;
        held_ok     = 1'b0;
        fault_seen  = 1'b0;
    endfunction

    // Only the first wrapper fault of a row is kept.
    function automatic void note_wrapper_fault(int unsigned where);
        if (!fault_seen)
        begin
            fault_seen = 1'b1;
            fault_pos  = where & 32'hFFFF;
        end
    endfunction

    // Text past the buffer length is dropped without a word marked valid.
    function automatic void emit_field_byte(logic [7:0] c, inout out_item_t r);
        if (field_len < TEXT_LIMIT)
        begin
            r.byte_valid  = 1'b1;
            r.out_char    = c;
            r.char_offset = field_len[6:0];
            field_len++;
        end
    endfunction

    // Result word caused by one header byte, advancing the row state.
    function automatic out_item_t split_header_byte(in_item_t w);
        out_item_t   r;
        int unsigned pos;
        status_t     st;
        r = '0;
        pos = row_pos;
        r.column_index = column_no;
        if (w.in_byte == NEWLINE_BYTE || w.in_byte == sep_reg)
        begin
            if (wrap_reg != 8'd0)
            begin
                if (pos == field_start)
                    note_wrapper_fault(field_start + 1);
                else if (held_ok && held_byte != wrap_reg)
                    note_wrapper_fault(pos - 1);
            end
            if (w.in_byte == NEWLINE_BYTE)
            begin
                if (pos == 0)
                    st = STATUS_EMPTY_LINE;
                else if (sep_count + 1 != cols_reg)
                    st = STATUS_COLUMN_MISMATCH;
                else if (fault_seen)
                    st = STATUS_WRAPPER_MISSING;
                else
                    st = STATUS_OK;
                r.field_end      = (pos != 0);
                r.row_done       = 1'b1;
                r.status         = st;
                r.fault_position = (st == STATUS_WRAPPER_MISSING) ? fault_pos[15:0] : 16'd0;
                clear_row_state();
                return r;
            end
            r.field_end = 1'b1;
            if (sep_count < 32'hFFFF)
                sep_count++;
            if (column_no < COLUMN_CAP)
                column_no++;
            field_start = pos + 1;
            field_len   = 0;
            held_ok     = 1'b0;
            held_byte   = 8'd0;
        end
        else if (wrap_reg != 8'd0)
        begin
            // The first byte of a field is its opening wrapper; every later
            // byte is held back in case it turns out to be the closing one.
            if (pos == field_start)
            begin
                if (w.in_byte != wrap_reg)
                    note_wrapper_fault(pos + 1);
            end
            else
            begin
                if (held_ok)
                    emit_field_byte(held_byte, r);
                held_byte = w.in_byte;
                held_ok   = 1'b1;
            end
        end
        else
            emit_field_byte(w.in_byte, r);

        row_pos = pos + 1;
        if (w.input_ends || row_pos >= ROW_LIMIT)
        begin
            r.row_done       = 1'b1;
            r.status         = STATUS_NO_NEWLINE;
            r.fault_position = 16'd0;
            clear_row_state();
        end
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned draw_gap(bit idles);
        int unsigned roll;
        if (!idles)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        if (roll < 98)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch at result word %0d: %s", words_checked, what);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
    endtask

    // Input side: offers queued words and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                split_words_due.push_back(split_header_byte(in_if.data));
                bytes_taken++;
            end
            if (!in_if.valid || in_if.ready)
            begin
                if (send_gap != 0)
                begin
                    in_if.valid <= 1'b0;
                    send_gap--;
                end
                else if (header_bytes_q.size() != 0)
                begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= header_bytes_q.pop_front();
                    send_gap = draw_gap(sender_idles);
                end
                else
                    in_if.valid <= 1'b0;
            end
        end
    end

    // Output side: checks each accepted word and drives ready.
    always @(posedge clk or negedge rst_n)
    begin : result_check
        out_item_t got;
        out_item_t want;
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                words_checked++;
                got = out_if.data;
                if (split_words_due.size() == 0)
                    report_mismatch("word arrived with none due");
                else
                begin
                    want = split_words_due.pop_front();
                    check_field("byte_valid", got.byte_valid, want.byte_valid);
                    check_field("out_char", got.out_char, want.out_char);
                    check_field("column_index", got.column_index, want.column_index);
                    check_field("char_offset", got.char_offset, want.char_offset);
                    check_field("field_end", got.field_end, want.field_end);
                    check_field("row_done", got.row_done, want.row_done);
                    check_field("status", got.status, want.status);
                    check_field("fault_position", got.fault_position, want.fault_position);
                end
            end
            if (receiver_hold != 0)
            begin
                out_if.ready <= 1'b0;
                receiver_hold--;
            end
            else if (take_gap != 0)
            begin
                out_if.ready <= 1'b0;
                take_gap--;
            end
            else
            begin
                out_if.ready <= 1'b1;
                take_gap = draw_gap(receiver_idles);
            end
        end
    end

    // Ends the run when nothing has moved on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_register(cfg_index_t idx, logic [8:0] value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{reg_index: idx, reg_value: value};
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_SEPARATOR_CHAR:   sep_reg  = value[7:0];
            CFG_WRAPPER_CHAR:     wrap_reg = value[7:0];
            CFG_EXPECTED_COLUMNS: cols_reg = value;
            default: ;
        endcase
    endtask

    task automatic configure_phase(logic [7:0] sep, logic [7:0] wrap, logic [8:0] cols);
        write_register(CFG_SEPARATOR_CHAR, {1'b0, sep});
        write_register(CFG_WRAPPER_CHAR, {1'b0, wrap});
        write_register(CFG_EXPECTED_COLUMNS, cols);
        sender_idles   = ($urandom_range(3) != 0);
        receiver_idles = ($urandom_range(3) != 0);
    endtask

    // Waits until every queued word has been taken and every result checked.
    task automatic drain_pipeline();
        while (bytes_taken != bytes_queued || split_words_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic push_word(logic [7:0] b, bit ends);
        header_bytes_q.push_back('{in_byte: b, input_ends: ends});
        bytes_queued++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_word(s[i], 1'b0);
    endtask

    // A byte that neither ends a field nor the row.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = $urandom_range(255);
        while (b == sep_reg || b == NEWLINE_BYTE);
        return b;
    endfunction

    // One row of the given column count under the current registers, with at
    // most one field spoilt when flaws are allowed.
    task automatic push_header_row(int unsigned columns, bit allow_flaw);
        int unsigned roll;
        int unsigned broken;
        int unsigned len;
        row_flaw_t   flaw;
        roll = allow_flaw ? $urandom_range(9) : 0;
        flaw = (roll < 7) ? ROW_CLEAN : row_flaw_t'(roll - 6);
        broken = $urandom_range(columns - 1);
        for (int unsigned c = 0; c < columns; c++)
        begin
            if (columns > 8)
                len = $urandom_range(2);
            else if ($urandom_range(19) == 0)
                len = $urandom_range(200, 100);
            else
                len = $urandom_range(6);
            if (c != 0)
                push_word(sep_reg, 1'b0);
            if (wrap_reg != 8'd0 && !(flaw == ROW_NO_OPENING && c == broken))
                push_word(wrap_reg, 1'b0);
            repeat (len) push_word(text_byte(), 1'b0);
            if (wrap_reg != 8'd0 && !(flaw == ROW_NO_CLOSING && c == broken))
                push_word(wrap_reg, 1'b0);
            if (flaw == ROW_CUT_SHORT && c == broken)
            begin
                push_word(text_byte(), 1'b1);
                return;
            end
        end
        push_word(NEWLINE_BYTE, 1'b0);
    endtask

    // A short burst weighted towards the bytes the splitter reacts to.
    task automatic push_noise();
        int unsigned count;
        logic [7:0]  b;
        count = $urandom_range(20, 1);
        repeat (count)
        begin
            case ($urandom_range(9))
                0, 1:    b = sep_reg;
                2, 3:    b = wrap_reg;
                4:       b = NEWLINE_BYTE;
                default: b = $urandom_range(255);
            endcase
            push_word(b, $urandom_range(24) == 0);
        end
    endtask

    task automatic push_random_rows(int unsigned budget);
        int unsigned first;
        int unsigned columns;
        int unsigned roll;
        first = bytes_queued;
        while (bytes_queued - first < budget)
        begin
            roll = $urandom_range(19);
            if (sep_reg == NEWLINE_BYTE)
                columns = 1;
            else if (cols_reg >= 1 && cols_reg <= 256)
                columns = cols_reg;
            else
                columns = $urandom_range(4, 1);
            if (roll < 14)
                push_header_row(columns, 1'b1);
            else if (roll < 16)
                push_header_row((columns > 1 && roll == 14) ? columns - 1 : columns + 1, 1'b1);
            else if (roll < 18)
                push_noise();
            else
                push_word(NEWLINE_BYTE, 1'b0);
        end
    endtask

    task automatic random_phase(logic [7:0] sep, logic [7:0] wrap, logic [8:0] cols);
        configure_phase(sep, wrap, cols);
        push_random_rows(PHASE_BYTES);
        drain_pipeline();
    endtask

    // Test sequence.
    initial
    begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        rst_n        = 1'b0;
        sep_reg      = SEPARATOR_RESET;
        wrap_reg     = WRAPPER_RESET;
        cols_reg     = COLUMNS_RESET;
        clear_row_state();
        bytes_queued   = 0;
        bytes_taken    = 0;
        words_checked  = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        receiver_hold  = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: empty line, good row, too many columns, a row
        // cut off by the end of input, extreme bytes and a newline that
        // also carries the end of input.
        push_word(NEWLINE_BYTE, 1'b0);
        push_text("id\n");
        push_text("a,b\n");
        push_word("z", 1'b1);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(NEWLINE_BYTE, 1'b1);
        drain_pipeline();

        // Quoted fields: a good row, a lone wrapper followed by an unwrapped
        // field, and an empty field.
        configure_phase(SEPARATOR_RESET, 8'd34, 9'd2);
        push_text("\"a\",\"b\"\n");
        push_text("\",x\n");
        push_text(",\"\"\n");
        drain_pipeline();

        // The receiver holds off while the sender keeps offering words.
        configure_phase(SEPARATOR_RESET, 8'd34, 9'd3);
        @(negedge clk);
        sender_idles  = 1'b0;
        receiver_hold = LONG_HOLD;
        push_random_rows(HOLD_BYTES);
        drain_pipeline();

        random_phase(SEPARATOR_RESET, 8'd0, 9'd4);
        random_phase(8'd9, 8'd39, 9'd5);
        random_phase(8'd0, 8'd255, 9'd2);
        random_phase(8'd255, 8'd0, 9'd1);
        random_phase(NEWLINE_BYTE, 8'd34, 9'd1);
        random_phase(8'd59, 8'd59, 9'd2);
        random_phase(SEPARATOR_RESET, 8'd0, 9'd0);
        random_phase(8'd124, 8'd0, 9'd511);

        // Widest row, then one whose column count saturates.
        configure_phase(SEPARATOR_RESET, 8'd0, 9'd256);
        push_header_row(256, 1'b0);
        push_header_row(270, 1'b0);
        drain_pipeline();

        repeat (3)
            random_phase(($urandom_range(3) == 0) ? SEPARATOR_RESET : 8'($urandom_range(255)),
                         $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 1)),
                         9'($urandom_range(6, 1)));

        // A long row cut off by the end of input, then a short row to show
        // that the row restarts cleanly.
        configure_phase(SEPARATOR_RESET, 8'd34, 9'd2);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (LONG_ROW_BYTES - 1)
            push_word(($urandom_range(7) == 0) ? sep_reg : text_byte(), 1'b0);
        push_word(text_byte(), 1'b1);
        push_header_row(2, 1'b0);
        drain_pipeline();

        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && split_words_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
